// File: rtl/core/bfs_adjacency_matrix_top_defines.svh
// Assertion macros shared by the checker of the breadth-first search block.
`ifndef BFS_ADJACENCY_MATRIX_TOP_DEFINES_SVH
`define BFS_ADJACENCY_MATRIX_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFS_AM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfs_am check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BFS_AM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfs_am check failed in the following cycle");

`endif

// File: rtl/core/bfs_am_pkg.sv
// Package with the types and constants of the breadth-first search block.
package bfs_am_pkg;

   localparam int FIELD_VERTICES       = 16;
   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam int COUNT_W              = 5;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [3:0]  row_index;
      logic [15:0] row_bits;
      logic [3:0]  source;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] vertex;
      logic       bad_source;
      logic       last;
   } rsp_payload_type;

endpackage

// File: rtl/core/bfs_adjacency_matrix_top.sv
// Breadth-first search over an adjacency bit matrix, with its sequencer and storage.
//
// Usage: the req_ channel carries items of two kinds. A load item writes one
// adjacency row and gives no result. A search item gives the source vertex,
// and the block then sends one rsp_ item per reached vertex in breadth-first
// order, with last set on the final one. A source at or beyond the vertex count
// gives a single item with bad_source and last set, through S_BAD and the output
// register. The csr_ channel writes vertex_count and is always ready; the user
// must write it only while the block is idle, as the block does not enforce it.
// A search is run by one sequencer: each dequeued vertex goes through a queue
// read (S_DEQ), a row read (S_ROW), a neighbour scan over every vertex in use
// (a single shared test-and-enqueue step, S_SCAN) and a hand-over of the result
// (S_EMIT). req_stall stays high until the search is over.
// The result sits in an output register, so the scan of the next vertex goes on
// while rsp_stall holds the current result; the sequencer waits only when a new
// result is ready and the register is still full.
// Reset (synchronous) clears the adjacency matrix, sets vertex_count to 16 and
// empties the output register.
module bfs_adjacency_matrix_top
   import bfs_am_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [COUNT_W-1:0]   csr_data
);

   localparam int NV = (MAX_VERTICES < FIELD_VERTICES) ? MAX_VERTICES : FIELD_VERTICES;
   localparam int IW = $clog2(NV);
   localparam int CW = $clog2(NV + 1);
   localparam logic [COUNT_W-1:0] NV_CNT = COUNT_W'(NV);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEQ  = 3'd1;
   localparam logic [2:0] S_ROW  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;
   localparam logic [2:0] S_BAD  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       head_ff, head_in;
   logic [CW-1:0]       tail_ff, tail_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic [NV-1:0]       row_ff, row_in;
   logic [NV-1:0]       visited_ff, visited_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;
   logic [NV-1:0]       adj_ff [NV];
   logic [3:0]          queue_mem [NV];
   logic [IW-1:0]       q_rd_ff;

   logic                req_take;
   logic                rsp_free;
   logic [COUNT_W-1:0]  eff_cnt;
   logic [CW-1:0]       n_cnt;
   logic                src_bad;
   logic                row_ok;
   logic                adj_we;
   logic                q_we;
   logic [IW-1:0]       q_waddr;
   logic [3:0]          q_wdata;
   logic                scan_hit;
   logic                scan_end;
   logic                run_done;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // The vertex count is saturated to the number of rows held.
   assign eff_cnt = (count_ff > NV_CNT) ? NV_CNT : count_ff;
   assign n_cnt   = eff_cnt[CW-1:0];
   assign src_bad = (COUNT_W'(req_data.source) >= eff_cnt);
   assign row_ok  = (COUNT_W'(req_data.row_index) < NV_CNT);

   assign scan_hit = row_ff[scan_ff] && !visited_ff[scan_ff] && (tail_ff < n_cnt);
   assign scan_end = ((CW'(scan_ff) + CW'(1)) == n_cnt);
   assign run_done = (head_ff == tail_ff);

   assign adj_we = req_take && (req_data.req_type == REQ_LOAD) && row_ok;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      scan_in      = scan_ff;
      row_in       = row_ff;
      visited_in   = visited_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_we         = 1'b0;
      q_waddr      = tail_ff[IW-1:0];
      q_wdata      = 4'(scan_ff);

      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take && (req_data.req_type == REQ_SEARCH)) begin
               if (src_bad) begin
                  state_in = S_BAD;
               end else begin
                  // The source is the first entry of a fresh queue.
                  q_we       = 1'b1;
                  q_waddr    = '0;
                  q_wdata    = req_data.source;
                  head_in    = '0;
                  tail_in    = CW'(1);
                  visited_in = NV'(1) << req_data.source[IW-1:0];
                  state_in   = S_DEQ;
               end
            end
         end
         S_DEQ: begin
            head_in  = head_ff + CW'(1);
            state_in = S_ROW;
         end
         S_ROW: begin
            row_in   = adj_ff[q_rd_ff];
            scan_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_hit) begin
               q_we                = 1'b1;
               tail_in             = tail_ff + CW'(1);
               visited_in[scan_ff] = 1'b1;
            end
            if (scan_end) begin
               state_in = S_EMIT;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.vertex     = 4'(q_rd_ff);
               rsp_data_in.bad_source = 1'b0;
               rsp_data_in.last       = run_done;
               state_in               = run_done ? S_IDLE : S_DEQ;
            end
         end
         S_BAD: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.vertex     = '0;
               rsp_data_in.bad_source = 1'b1;
               rsp_data_in.last       = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         visited_ff   <= '0;
         count_ff     <= VERTEX_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         visited_ff   <= visited_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NV; r++) begin
            adj_ff[r] <= '0;
         end
      end else if (adj_we) begin
         adj_ff[req_data.row_index[IW-1:0]] <= req_data.row_bits[NV-1:0];
      end
   end

   // Queue memory: written at the tail, read at the head with a registered output.
   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      if (state_ff == S_DEQ) begin
         q_rd_ff <= queue_mem[head_ff[IW-1:0]][IW-1:0];
      end
   end

endmodule

// File: rtl/core/bfs_am_checker.sv
// Port-level checker for the breadth-first search block, bound to its top level.
`include "bfs_adjacency_matrix_top_defines.svh"

module bfs_am_checker
   import bfs_am_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input req_payload_type    req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input rsp_payload_type    rsp_data
);

   // A held result keeps its valid and its payload.
   `BFS_AM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))

   // An error result carries vertex zero and closes the run.
   `BFS_AM_ASSERT_NOW(a_bad_form, clock, reset, rsp_valid && rsp_data.bad_source,
      rsp_data.last && (rsp_data.vertex == 4'd0))

   // Once a search item is taken the block is busy in the next cycle.
   `BFS_AM_ASSERT_NEXT(a_search_busy, clock, reset,
      req_valid && !req_stall && (req_data.req_type == REQ_SEARCH), req_stall)

   // Reset leaves no result pending.
   `BFS_AM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind bfs_adjacency_matrix_top bfs_am_checker u_bfs_am_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for the breadth-first search block and its visit order.
module tb_top;
   import bfs_am_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 32;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int HOLD_CYCLES    = 200;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 17;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_payload_type    req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_payload_type    rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data;

   // Predictor state: the adjacency matrix and the vertex count as the block should hold them.
   logic [15:0]        adj_rows [FIELD_VERTICES];
   logic [COUNT_W-1:0] count_setting;
   rsp_payload_type    pending_visits [$];

   bit sender_idles;
   bit receiver_idles;
   int hold_cycles = 0;
   int errors = 0;
   int items_sent = 0;
   int searches_sent = 0;
   int results_checked = 0;
   int settings_used = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   bfs_adjacency_matrix_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Works out the results of one accepted item and queues them in visit order.
   function automatic void predict_visits(input req_payload_type item);
      int unsigned     n;
      int unsigned     head;
      int unsigned     tail;
      int unsigned     i;
      logic [3:0]      x;
      logic [15:0]     seen;
      logic [3:0]      order [FIELD_VERTICES];
      rsp_payload_type r;
      n = (count_setting > FIELD_VERTICES) ? FIELD_VERTICES : count_setting;
      if (item.req_type == REQ_LOAD) begin
         adj_rows[item.row_index] = item.row_bits;
      end else if (item.source >= n) begin
         r.vertex     = '0;
         r.bad_source = 1'b1;
         r.last       = 1'b1;
         pending_visits.push_back(r);
      end else begin
         seen              = '0;
         seen[item.source] = 1'b1;
         order[0]          = item.source;
         head              = 0;
         tail              = 1;
         while (head < tail && head < n) begin
            x = order[head];
            head++;
            for (i = 0; i < n; i++) begin
               if (adj_rows[x][i] && !seen[i] && tail < n) begin
                  order[tail] = 4'(i);
                  tail++;
                  seen[i] = 1'b1;
               end
            end
            r.vertex     = x;
            r.bad_source = 1'b0;
            r.last       = (head == tail);
            pending_visits.push_back(r);
         end
      end
   endfunction

   // The valid is left high on return so that back-to-back items need no second assignment.
   task automatic send_item(input req_payload_type item);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_visits(item);
      items_sent++;
      if (item.req_type == REQ_SEARCH) searches_sent++;
   endtask

   task automatic load_row(input logic [3:0] row, input logic [15:0] bits);
      req_payload_type item;
      item.req_type  = REQ_LOAD;
      item.row_index = row;
      item.row_bits  = bits;
      item.source    = 4'($urandom);
      send_item(item);
   endtask

   task automatic search_from(input logic [3:0] src);
      req_payload_type item;
      item.req_type  = REQ_SEARCH;
      item.row_index = 4'($urandom);
      item.row_bits  = 16'($urandom);
      item.source    = src;
      send_item(item);
   endtask

   // A trailing load gives no result, so a further SETTLE_CYCLES wait is allowed for it after the queue drains.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_visits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_setting = value;
      settings_used++;
   endtask

   task automatic test_empty_graph();
      search_from(4'd0);
      search_from(4'd15);
      load_row(4'd9, 16'h0000);
      search_from(4'd9);
   endtask

   task automatic test_directed_graphs();
      // Row 0 reaches everything, including itself.
      load_row(4'd0, 16'hFFFF);
      search_from(4'd0);
      load_row(4'd15, 16'h8001);
      search_from(4'd15);
      load_row(4'd7, 16'h0088);
      search_from(4'd7);
      // Vertices 3 and 7 point at each other, so the cycle must not be revisited.
      load_row(4'd3, 16'h0080);
      search_from(4'd3);
   endtask

   task automatic test_count_limits();
      write_vertex_count(5'd8);
      search_from(4'd12);
      search_from(4'd0);
      search_from(4'd7);
      write_vertex_count(5'd1);
      search_from(4'd0);
      search_from(4'd1);
      write_vertex_count(5'd0);
      search_from(4'd0);
      // Counts above sixteen saturate.
      write_vertex_count(5'd31);
      search_from(4'd15);
      write_vertex_count(VERTEX_COUNT_RESET);
   endtask

   task automatic test_backpressure();
      int k;
      load_row(4'd5, 16'hFFFF);
      hold_cycles = HOLD_CYCLES;
      search_from(4'd5);
      for (k = 0; k < 4; k++) load_row(4'($urandom), 16'($urandom));
      search_from(4'($urandom));
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int                 phase;
      int                 k;
      int                 n;
      logic [COUNT_W-1:0] setting;
      req_payload_type    item;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0:       setting = 5'd1;
            1:       setting = 5'd16;
            2:       setting = 5'($urandom_range(0, 31));
            default: setting = 5'($urandom_range(2, 16));
         endcase
         write_vertex_count(setting);
         // The closing phases run with no idling on either side.
         sender_idles   = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         receiver_idles = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
         n = (count_setting > FIELD_VERTICES) ? FIELD_VERTICES : count_setting;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            item.row_index = 4'($urandom);
            item.row_bits  = 16'($urandom);
            item.source    = 4'($urandom);
            if ($urandom_range(0, 9) < 6) begin
               item.req_type = REQ_LOAD;
               if (n > 0 && $urandom_range(0, 3) != 0)
                  item.row_index = 4'($urandom_range(0, n - 1));
               case ($urandom_range(0, 2))
                  0:       item.row_bits = 16'($urandom & $urandom & $urandom);
                  1:       item.row_bits = 16'($urandom | $urandom);
                  default: ;
               endcase
            end else begin
               item.req_type = REQ_SEARCH;
               if (n > 0 && $urandom_range(0, 9) != 0)
                  item.source = 4'($urandom_range(0, n - 1));
            end
            send_item(item);
         end
      end
   endtask

   initial begin : receiver
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_checker
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_visits.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected: vertex %0d bad_source %0b last %0b",
                     $time, rsp_data.vertex, rsp_data.bad_source, rsp_data.last);
         end else begin
            want = pending_visits.pop_front();
            results_checked++;
            if (rsp_data.vertex !== want.vertex || rsp_data.bad_source !== want.bad_source ||
                rsp_data.last !== want.last) begin
               errors++;
               $display("%0t: expected vertex %0d bad_source %0b last %0b", $time,
                        want.vertex, want.bad_source, want.last);
               $display("%0t: actual   vertex %0d bad_source %0b last %0b", $time,
                        rsp_data.vertex, rsp_data.bad_source, rsp_data.last);
            end
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("bfs_adjacency_matrix_top regression: fail");
      $finish;
   end

   initial begin : main
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      count_setting = VERTEX_COUNT_RESET;
      foreach (adj_rows[r]) adj_rows[r] = '0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_graph();
      test_directed_graphs();
      test_count_limits();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      $display("Sent %0d items including %0d searches; %0d results checked.",
               items_sent, searches_sent, results_checked);
      $display("Vertex count written %0d times, covering zero, one, sixteen and saturation.",
               settings_used);
      if (errors == 0) begin
         $display("bfs_adjacency_matrix_top regression: pass");
      end else begin
         $display("bfs_adjacency_matrix_top regression: fail");
      end
      $finish;
   end

endmodule
